// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded deque package
// Depth, command and status codes, and the beat types of the deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Number of words the deque holds.
  localparam int DEPTH = 16;
  // Width of a word count from zero to DEPTH, and of a cell index.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int FILL_W = 5;

  // Commands.
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_REAR   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] push_value;
  } bdq_in_t;

  // Result beat.
  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [FILL_W-1:0]  fill_count;
    logic               is_empty;
    logic               is_full;
  } bdq_out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             push_front;
    logic             pop_front;
    logic             push_rear;
    logic [CNT_W-1:0] count;
  } bdq_ctrl_t;

endpackage

// ===== rtl/bounded_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Bounded double-ended queue
// Push and front-pop results appear in the cycle after the beat; busy stays low.
// A rear pop on stored words raises busy while the tail word walks one cell a cycle
// down the chain to the front; the result is registered once it reaches cell 0.
// Throughput: one beat per cycle except during a rear-pop walk.
// Reset clears the count and control; stored words are undefined until written.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue import bdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  bdq_in_t  cmd_in,
  output logic     done,
  output bdq_out_t result
);

  `include "assert_macros.svh"

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [IDX_W-1:0]   walk;
  logic               accept;
  logic               finish;
  logic               walk_start;
  logic               res_valid;
  logic [1:0]         res_status;
  logic signed [31:0] res_pop;
  logic               is_full_now;
  logic               is_empty_now;
  bdq_ctrl_t          ctrl;

  logic signed [31:0] word_q [DEPTH];
  logic signed [31:0] rd_q   [DEPTH];

  assign accept       = start && !busy;
  assign finish       = busy && (walk == '0);
  assign is_full_now  = (count == CNT_W'(DEPTH));
  assign is_empty_now = (count == '0);

  // Command decode and next count.
  always_comb begin
    ctrl.push_front = 1'b0;
    ctrl.pop_front  = 1'b0;
    ctrl.push_rear  = 1'b0;
    ctrl.count      = count;
    count_next      = count;
    res_valid       = 1'b0;
    res_status      = ST_OK;
    res_pop         = '0;
    walk_start      = 1'b0;
    if (finish) begin
      res_valid  = 1'b1;
      res_pop    = rd_q[0];
      count_next = count - 1'b1;
    end else if (accept) begin
      unique case (cmd_in.command)
        CMD_PUSH_FRONT: begin
          res_valid = 1'b1;
          if (is_full_now) begin
            res_status = ST_FULL;
          end else begin
            ctrl.push_front = 1'b1;
            count_next      = count + 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          res_valid = 1'b1;
          if (is_full_now) begin
            res_status = ST_FULL;
          end else begin
            ctrl.push_rear = 1'b1;
            count_next     = count + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          res_valid = 1'b1;
          if (is_empty_now) begin
            res_status = ST_EMPTY;
          end else begin
            ctrl.pop_front = 1'b1;
            res_pop        = word_q[0];
            count_next     = count - 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (is_empty_now) begin
            res_valid  = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            walk_start = 1'b1;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Control state: count, walk sequencer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      walk  <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= res_valid;
      if (walk_start) begin
        busy <= 1'b1;
        walk <= IDX_W'(count - 1'b1);
      end else if (finish) begin
        busy <= 1'b0;
      end else if (busy) begin
        walk <= walk - 1'b1;
      end
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      result.popped_value <= res_pop;
      result.status       <= res_status;
      result.fill_count   <= FILL_W'(count_next);
      result.is_empty     <= (count_next == '0);
      result.is_full      <= (count_next == CNT_W'(DEPTH));
    end
  end

  // Chain of cells; cell 0 holds the front word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_word;
    logic signed [31:0] right_word;
    logic signed [31:0] right_rd;

    if (i == 0) begin : g_first
      assign left_word = cmd_in.push_value;
    end else begin : g_mid_left
      assign left_word = word_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = word_q[i];
      assign right_rd   = word_q[i];
    end else begin : g_mid_right
      assign right_word = word_q[i+1];
      assign right_rd   = rd_q[i+1];
    end

    bdq_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .in_word    (cmd_in.push_value),
      .left_word  (left_word),
      .right_word (right_word),
      .right_rd   (right_rd),
      .word       (word_q[i]),
      .rd         (rd_q[i])
    );
  end

  // Checks on the count and the rear-pop walk.
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "count exceeds depth")
  `ASSERT_IMPLIES(a_busy_nonempty, clk, rst, busy, count != '0, "walk running on empty deque")
  `ASSERT_NEXT(a_rear_walk, clk, rst,
               accept && cmd_in.command == CMD_POP_REAR && count != '0,
               busy && !done, "rear pop did not start a walk")
  `ASSERT_IMPLIES(a_refused_zero, clk, rst, done && result.status != ST_OK,
                  result.popped_value == '0, "refused beat carries a word")

endmodule

// ===== rtl/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// Deque cell
// One word of the deque chain, with the read-walk register beside it.
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  bdq_ctrl_t          ctrl,
  input  logic signed [31:0] in_word,
  input  logic signed [31:0] left_word,
  input  logic signed [31:0] right_word,
  input  logic signed [31:0] right_rd,
  output logic signed [31:0] word,
  output logic signed [31:0] rd
);

  logic signed [31:0] word_next;
  logic               is_tail;
  logic               is_slot;

  // The tail word sits one below the count; a rear push lands at the count.
  assign is_tail = (ctrl.count == CNT_W'(IDX + 1));
  assign is_slot = (ctrl.count == CNT_W'(IDX));

  // Shift toward the rear, shift toward the front, or take a rear push.
  always_comb begin
    word_next = word;
    priority if (ctrl.push_front) begin
      word_next = left_word;
    end else if (ctrl.pop_front) begin
      word_next = right_word;
    end else if (ctrl.push_rear && is_slot) begin
      word_next = in_word;
    end else begin
      word_next = word;
    end
  end

  // Word storage; undefined until written.
  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // The tail word walks one cell toward the front each cycle.
  always_ff @(posedge clk) begin
    rd <= is_tail ? word : right_rd;
  end

endmodule
